### src/pwfe_pkg.sv
// Shared types and constants for the pulse waveform feature extractor.
// Holds the field widths, configuration register indexes, the controller state enum and the
// command/status structs. Depends on nothing.
package pwfe_pkg;

  // Fixed field widths of the ports.
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned START_W    = 10;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned BQ_W       = 20;
  localparam int unsigned RQ_W       = 19;
  localparam int unsigned POS_OUT_W  = 10;
  localparam int unsigned TOTAL_W    = 11;
  localparam int unsigned INT_W      = 26;

  // Number of fraction bits of the baseline and RMS results.
  localparam int unsigned Q_FRAC     = 4;

  // Saturation level of the integral field.
  localparam logic [INT_W-1:0] INTEGRAL_MAX = 26'h3FF_FFFF;

  // Defaults of the top-level parameters.
  localparam int unsigned DEF_MAX_SAMPLES = 1024;
  localparam int unsigned DEF_SAMPLE_BITS = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_START    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_START    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEGATIVE_POLARITY = 3'd4;

  // Configuration reset values.
  localparam logic [START_W-1:0] RST_BASELINE_START = 10'd0;
  localparam logic [CNT_W-1:0]   RST_BASELINE_COUNT = 11'd16;
  localparam logic [START_W-1:0] RST_INTEGRAL_START = 10'd0;
  localparam logic [CNT_W-1:0]   RST_INTEGRAL_COUNT = 11'd1024;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SPREAD,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_RMS_GO,
    ST_RMS_WAIT,
    ST_FINISH
  } pwfe_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sample_en;   // accept the word on the input channel
    logic close;       // the accepted word is the last one: snapshot and clear
    logic mul_lo;      // n times low half of the square sum, and sum squared
    logic mul_hi;      // n times high half of the square sum
    logic spread;      // combine the products into the scaled spread
    logic root_start;  // start the square root
    logic div_start;   // start the divider
    logic div_rms;     // divider operand: 1 selects the root, 0 the scaled sum
    logic cap_base;    // capture the baseline quotient
    logic out_load;    // load the result word into the output register
  } pwfe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sqrt_busy;
    logic div_busy;
    logic out_free;
  } pwfe_stat_t;

endpackage

### src/pwfe_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Digit-by-digit method on a radicand of RAD_W bits. Depends on nothing.
module pwfe_sqrt #(
  parameter int unsigned RAD_W = 62
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [RAD_W-1:0]     radicand_i,
  output logic                 busy_o,
  output logic [RAD_W/2-1:0]   root_o
);

  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned CAND_W = REM_W + 2;
  localparam int unsigned STEP_W = $clog2(ROOT_W + 1);

  logic [STEP_W-1:0] step_q;
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;

  logic [CAND_W-1:0] cand;
  logic [CAND_W-1:0] trial;
  logic [CAND_W-1:0] diff;
  logic              fits;

  // One step: bring down two radicand bits and try the next root bit.
  always_comb begin
    cand  = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial = CAND_W'({root_q, 2'b01});
    fits  = cand >= trial;
    diff  = cand - trial;
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= STEP_W'(ROOT_W);
    end else if (busy_o) begin
      step_q <= step_q - 1'b1;
    end
  end

  // Radicand, remainder and root.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_o) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? diff[REM_W-1:0] : cand[REM_W-1:0];
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  assign busy_o = step_q != '0;
  assign root_o = root_q;

endmodule

### src/pwfe_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Divides a DVD_W-bit dividend by a DVS_W-bit divisor. Depends on nothing.
module pwfe_div #(
  parameter int unsigned DVD_W = 31,
  parameter int unsigned DVS_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(DVD_W + 1);

  logic [STEP_W-1:0] step_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W-1:0]  rem_q;

  logic [DVS_W:0]    cand;
  logic [DVS_W:0]    diff;
  logic              fits;

  // One step: shift in the next dividend bit and subtract when it fits.
  always_comb begin
    cand = {rem_q, dvd_q[DVD_W-1]};
    fits = cand >= {1'b0, dvs_q};
    diff = cand - {1'b0, dvs_q};
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= STEP_W'(DVD_W);
    end else if (busy_o) begin
      step_q <= step_q - 1'b1;
    end
  end

  // The dividend register fills with quotient bits from the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_o) begin
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
      rem_q <= fits ? diff[DVS_W-1:0] : cand[DVS_W-1:0];
    end
  end

  assign busy_o     = step_q != '0;
  assign quotient_o = dvd_q;

endmodule

### src/pwfe_datapath.sv
// Datapath of the pulse waveform feature extractor: configuration registers, running
// accumulators, result arithmetic and the output register.
// Depends on pwfe_pkg, pwfe_sqrt and pwfe_div.
module pwfe_datapath
  import pwfe_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pwfe_cmd_t            cmd_i,
  output pwfe_stat_t           stat_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  input  logic [SAMPLE_W-1:0]  sample_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [BQ_W-1:0]      baseline_q4_o,
  output logic [RQ_W-1:0]      rms_q4_o,
  output logic                 baseline_valid_o,
  output logic [SAMPLE_W-1:0]  peak_value_o,
  output logic [POS_OUT_W-1:0] peak_position_o,
  output logic [INT_W-1:0]     integral_o,
  output logic [TOTAL_W-1:0]   sample_total_o,
  output logic                 overflow_o
);

  localparam int unsigned IDX_W   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned POS_W   = $clog2(MAX_SAMPLES);
  localparam int unsigned CMP_W   = (IDX_W > CNT_W + 1) ? IDX_W : CNT_W + 1;
  localparam int unsigned SS_W    = 2 * SAMPLE_BITS;
  localparam int unsigned SUM_W   = SAMPLE_BITS + CNT_W;
  localparam int unsigned SQ_W    = SS_W + CNT_W;
  localparam int unsigned LO_W    = SQ_W / 2;
  localparam int unsigned HI_W    = SQ_W - LO_W;
  localparam int unsigned SPR_W   = SQ_W + CNT_W;
  localparam int unsigned RAD_W   = SPR_W + 2 * Q_FRAC;
  localparam int unsigned DIV_W   = RAD_W / 2;
  localparam int unsigned POS_X_W = (POS_W > POS_OUT_W) ? POS_W : POS_OUT_W;
  localparam int unsigned TOT_X_W = (IDX_W > TOTAL_W) ? IDX_W : TOTAL_W;
  localparam int unsigned INT_X_W = (SUM_W > INT_W) ? SUM_W : INT_W;

  // Configuration registers.
  logic [START_W-1:0] base_start_q;
  logic [CNT_W-1:0]   base_count_q;
  logic [START_W-1:0] int_start_q;
  logic [CNT_W-1:0]   int_count_q;
  logic               neg_pol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_start_q <= RST_BASELINE_START;
      base_count_q <= RST_BASELINE_COUNT;
      int_start_q  <= RST_INTEGRAL_START;
      int_count_q  <= RST_INTEGRAL_COUNT;
      neg_pol_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASELINE_START:    base_start_q <= cfg_data_i[START_W-1:0];
        CFG_BASELINE_COUNT:    base_count_q <= cfg_data_i;
        CFG_INTEGRAL_START:    int_start_q  <= cfg_data_i[START_W-1:0];
        CFG_INTEGRAL_COUNT:    int_count_q  <= cfg_data_i;
        CFG_NEGATIVE_POLARITY: neg_pol_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Running accumulators of the waveform in progress.
  logic [IDX_W-1:0]       idx_q,    idx_d;
  logic [SUM_W-1:0]       sum_q,    sum_d;
  logic [SQ_W-1:0]        sumsq_q,  sumsq_d;
  logic [CNT_W-1:0]       n_q,      n_d;
  logic [SAMPLE_BITS-1:0] best_q,   best_d;
  logic [POS_W-1:0]       pos_q,    pos_d;
  logic [SUM_W-1:0]       win_q,    win_d;
  logic                   over_q,   over_d;

  logic [SAMPLE_BITS-1:0] smp;
  logic [SS_W-1:0]        smp_sq;
  logic [CMP_W-1:0]       idx_x;
  logic                   in_base;
  logic                   in_win;
  logic                   full;
  logic                   take_peak;

  // Window membership of the current index and the per-word update.
  always_comb begin
    smp       = sample_i[SAMPLE_BITS-1:0];
    smp_sq    = SS_W'(smp) * SS_W'(smp);
    idx_x     = CMP_W'(idx_q);
    in_base   = (idx_x >= CMP_W'(base_start_q)) &&
                (idx_x < CMP_W'(base_start_q) + CMP_W'(base_count_q));
    in_win    = (idx_x >= CMP_W'(int_start_q)) &&
                (idx_x < CMP_W'(int_start_q) + CMP_W'(int_count_q));
    full      = idx_q >= IDX_W'(MAX_SAMPLES);
    // The first word always seeds the minimum; the maximum starts from zero.
    take_peak = neg_pol_q ? ((idx_q == '0) || (smp < best_q)) : (smp > best_q);

    idx_d   = idx_q;
    sum_d   = sum_q;
    sumsq_d = sumsq_q;
    n_d     = n_q;
    best_d  = best_q;
    pos_d   = pos_q;
    win_d   = win_q;
    over_d  = over_q;
    if (full) begin
      over_d = 1'b1;
    end else begin
      idx_d = idx_q + 1'b1;
      if (in_base) begin
        sum_d   = sum_q + SUM_W'(smp);
        sumsq_d = sumsq_q + SQ_W'(smp_sq);
        n_d     = n_q + 1'b1;
      end
      if (in_win) begin
        win_d = win_q + SUM_W'(smp);
      end
      if (take_peak) begin
        best_d = smp;
        pos_d  = idx_q[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      n_q     <= '0;
      best_q  <= '0;
      pos_q   <= '0;
      win_q   <= '0;
      over_q  <= 1'b0;
    end else if (cmd_i.close) begin
      idx_q   <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      n_q     <= '0;
      best_q  <= '0;
      pos_q   <= '0;
      win_q   <= '0;
      over_q  <= 1'b0;
    end else if (cmd_i.sample_en) begin
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      sumsq_q <= sumsq_d;
      n_q     <= n_d;
      best_q  <= best_d;
      pos_q   <= pos_d;
      win_q   <= win_d;
      over_q  <= over_d;
    end
  end

  // Snapshot of the closed waveform, including its last word.
  logic [IDX_W-1:0]       snap_idx_q;
  logic [SUM_W-1:0]       snap_sum_q;
  logic [SQ_W-1:0]        snap_sumsq_q;
  logic [CNT_W-1:0]       snap_n_q;
  logic [SAMPLE_BITS-1:0] snap_best_q;
  logic [POS_W-1:0]       snap_pos_q;
  logic [SUM_W-1:0]       snap_win_q;
  logic                   snap_over_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.close) begin
      snap_idx_q   <= idx_d;
      snap_sum_q   <= sum_d;
      snap_sumsq_q <= sumsq_d;
      snap_n_q     <= n_d;
      snap_best_q  <= best_d;
      snap_pos_q   <= pos_d;
      snap_win_q   <= win_d;
      snap_over_q  <= over_d;
    end
  end

  // Spread n*sumsq - sum*sum, with the square sum split into two narrower products.
  logic [CNT_W+LO_W-1:0] prod_lo_q;
  logic [CNT_W+HI_W-1:0] prod_hi_q;
  logic [SPR_W-1:0]      sq_q;
  logic [RAD_W-1:0]      rad_q;
  logic [SPR_W-1:0]      spread;

  assign spread = (SPR_W'(prod_hi_q) << LO_W) + SPR_W'(prod_lo_q) - sq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      prod_lo_q <= (CNT_W + LO_W)'(snap_n_q) * (CNT_W + LO_W)'(snap_sumsq_q[LO_W-1:0]);
      sq_q      <= SPR_W'(snap_sum_q) * SPR_W'(snap_sum_q);
    end
    if (cmd_i.mul_hi) begin
      prod_hi_q <= (CNT_W + HI_W)'(snap_n_q) * (CNT_W + HI_W)'(snap_sumsq_q[SQ_W-1:LO_W]);
    end
    if (cmd_i.spread) begin
      rad_q <= {spread, {(2 * Q_FRAC){1'b0}}};
    end
  end

  // Square root of the scaled spread and the shared divider.
  logic             sqrt_busy;
  logic [DIV_W-1:0] root;
  logic             div_busy;
  logic [DIV_W-1:0] div_dvd;
  logic [DIV_W-1:0] quot;
  logic [BQ_W-1:0]  bq_q;

  pwfe_sqrt #(
    .RAD_W (RAD_W)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.root_start),
    .radicand_i (rad_q),
    .busy_o     (sqrt_busy),
    .root_o     (root)
  );

  assign div_dvd = cmd_i.div_rms ? root : DIV_W'({snap_sum_q, {Q_FRAC{1'b0}}});

  pwfe_div #(
    .DVD_W (DIV_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (snap_n_q),
    .busy_o     (div_busy),
    .quotient_o (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_base) begin
      bq_q <= quot[BQ_W-1:0];
    end
  end

  // Output register.
  logic                 out_valid_q;
  logic                 base_ok;
  logic [POS_X_W-1:0]   pos_x;
  logic [TOT_X_W-1:0]   tot_x;
  logic [INT_X_W-1:0]   win_x;

  always_comb begin
    base_ok = snap_n_q != '0;
    pos_x   = POS_X_W'(snap_pos_q);
    tot_x   = TOT_X_W'(snap_idx_q);
    win_x   = INT_X_W'(snap_win_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      baseline_q4_o    <= base_ok ? bq_q : '0;
      rms_q4_o         <= base_ok ? quot[RQ_W-1:0] : '0;
      baseline_valid_o <= base_ok;
      peak_value_o     <= SAMPLE_W'(snap_best_q);
      peak_position_o  <= pos_x[POS_OUT_W-1:0];
      integral_o       <= (win_x > INT_X_W'(INTEGRAL_MAX)) ? INTEGRAL_MAX : win_x[INT_W-1:0];
      sample_total_o   <= tot_x[TOTAL_W-1:0];
      overflow_o       <= snap_over_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stat_o.sqrt_busy = sqrt_busy;
  assign stat_o.div_busy  = div_busy;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  // Checks on the datapath.
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_W'(MAX_SAMPLES))
    else $error("sample index ran past capacity");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.close |=> (idx_q == '0) && (n_q == '0) && !over_q)
    else $error("accumulators not cleared after the last word");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("loaded result not presented");

  a_root_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.root_start |-> !sqrt_busy)
    else $error("square root restarted while busy");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

### src/pwfe_ctrl.sv
// Controller of the pulse waveform feature extractor: sequences the result arithmetic
// after the last word of a waveform. Depends on pwfe_pkg.
module pwfe_ctrl
  import pwfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       last_i,
  output logic       in_stall_o,
  input  pwfe_stat_t stat_i,
  output pwfe_cmd_t  cmd_o
);

  pwfe_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && last_i) state_d = ST_MUL_LO;
      end
      ST_MUL_LO:  state_d = ST_MUL_HI;
      ST_MUL_HI:  state_d = ST_SPREAD;
      ST_SPREAD:  state_d = ST_ROOT_GO;
      ST_ROOT_GO: state_d = ST_ROOT_WAIT;
      ST_ROOT_WAIT: begin
        if (!stat_i.sqrt_busy && !stat_i.div_busy) state_d = ST_RMS_GO;
      end
      ST_RMS_GO:  state_d = ST_RMS_WAIT;
      ST_RMS_WAIT: begin
        if (!stat_i.div_busy) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.sample_en = in_valid_i;
        cmd_o.close     = in_valid_i && last_i;
      end
      ST_MUL_LO: cmd_o.mul_lo = 1'b1;
      ST_MUL_HI: cmd_o.mul_hi = 1'b1;
      ST_SPREAD: cmd_o.spread = 1'b1;
      ST_ROOT_GO: begin
        cmd_o.root_start = 1'b1;
        cmd_o.div_start  = 1'b1;
      end
      ST_RMS_GO: begin
        cmd_o.cap_base  = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_rms   = 1'b1;
      end
      ST_RMS_WAIT: cmd_o.div_rms = 1'b1;
      ST_FINISH:   cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

  // Checks on the sequencing.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free)
    else $error("result loaded over a pending word");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat_i.sqrt_busy || stat_i.div_busy) |-> in_stall_o)
    else $error("input open while the result arithmetic runs");

  a_close_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.close |=> (state_q == ST_MUL_LO))
    else $error("last word did not start the result sequence");

endmodule

### src/pulse_waveform_feature_extractor.sv
// Top level of the pulse waveform feature extractor.
// Joins the controller and the datapath. Depends on pwfe_pkg, pwfe_ctrl and pwfe_datapath.
//
// The block takes one ADC sample word per clock on its input channel while it is idle and
// keeps running sums for the baseline window, the integration window and the peak. The word
// marked last closes the waveform: the sums are captured and cleared, so the next waveform
// may begin as soon as the result is loaded into the output register, even while it still
// waits on the output channel. Computing the result stalls the input, as does waiting for a
// free output register; the stall is set by the square root and the divider, each producing
// one result bit per cycle for a SAMPLE_BITS + 15 bit result, the baseline division running
// alongside the root and the RMS division after it. Words other than the last do not stall.
module pulse_waveform_feature_extractor
  import pwfe_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [BQ_W-1:0]      baseline_q4_o,
  output logic [RQ_W-1:0]      rms_q4_o,
  output logic                 baseline_valid_o,
  output logic [SAMPLE_W-1:0]  peak_value_o,
  output logic [POS_OUT_W-1:0] peak_position_o,
  output logic [INT_W-1:0]     integral_o,
  output logic [TOTAL_W-1:0]   sample_total_o,
  output logic                 overflow_o
);

  pwfe_cmd_t  cmd;
  pwfe_stat_t stat;

  pwfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pwfe_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .baseline_q4_o    (baseline_q4_o),
    .rms_q4_o         (rms_q4_o),
    .baseline_valid_o (baseline_valid_o),
    .peak_value_o     (peak_value_o),
    .peak_position_o  (peak_position_o),
    .integral_o       (integral_o),
    .sample_total_o   (sample_total_o),
    .overflow_o       (overflow_o)
  );

endmodule
